FILE: design/jsu_pkg.sv
// jsu_pkg: shared codes and the per-byte step record for the json string unescaper
// no dependencies; used by jsu_decode and json_string_unescape
`timescale 1ns / 1ps

package jsu_pkg;

  // parser phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TEXT = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX1 = 3'd3;
  localparam logic [2:0] PH_HEX4 = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error causes
  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_NO_QUOTE = 3'd1;
  localparam logic [2:0] CAUSE_ZERO     = 3'd2;
  localparam logic [2:0] CAUSE_BAD_ESC  = 3'd3;
  localparam logic [2:0] CAUSE_BAD_HEX  = 3'd4;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  // utf-8 range limits
  localparam logic [15:0] CP_MAX1 = 16'h007f;
  localparam logic [15:0] CP_MAX2 = 16'h07ff;

  // outcome of one input byte
  typedef struct packed {
    logic [2:0]  phase_nxt;
    logic [15:0] cp_nxt;
    logic        clear_len;
    logic [1:0]  res_cnt;
    logic [1:0]  kind;
    logic [2:0]  cause;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
  } step_t;

endpackage

FILE: design/jsu_decode.sv
// jsu_decode: combinational decode of one string byte against the parser state
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_decode (
  input  logic [2:0]     phase,
  input  logic [15:0]    code_point,
  input  logic [7:0]     in_char,
  output jsu_pkg::step_t step
);

  logic [2:0]  ph;
  logic        is_dig;
  logic        is_alpha;
  logic [3:0]  hv;
  logic [15:0] cp_new;

  always_comb begin
    ph       = (phase > jsu_pkg::PH_HEX4) ? jsu_pkg::PH_IDLE : phase;
    is_dig   = (in_char >= 8'h30) && (in_char <= 8'h39);
    is_alpha = ((in_char >= 8'h41) && (in_char <= 8'h46)) ||
               ((in_char >= 8'h61) && (in_char <= 8'h66));
    hv       = is_dig ? in_char[3:0] : (in_char[3:0] + 4'd9);
    cp_new   = {code_point[11:0], hv};

    step           = '0;
    step.phase_nxt = ph;
    step.cp_nxt    = code_point;
    step.kind      = jsu_pkg::KIND_DATA;
    step.cause     = jsu_pkg::CAUSE_NONE;

    if (ph == jsu_pkg::PH_IDLE) begin
      if (in_char != jsu_pkg::CH_QUOTE) begin
        step.res_cnt = 2'd1;
        step.kind    = jsu_pkg::KIND_ERROR;
        step.cause   = jsu_pkg::CAUSE_NO_QUOTE;
      end else begin
        step.phase_nxt = jsu_pkg::PH_TEXT;
        step.clear_len = 1'b1;
        step.cp_nxt    = '0;
      end
    end else if (in_char == 8'h00) begin
      step.phase_nxt = jsu_pkg::PH_IDLE;
      step.res_cnt   = 2'd1;
      step.kind      = jsu_pkg::KIND_ERROR;
      step.cause     = jsu_pkg::CAUSE_ZERO;
    end else if (ph == jsu_pkg::PH_TEXT) begin
      if (in_char == jsu_pkg::CH_QUOTE) begin
        step.phase_nxt = jsu_pkg::PH_IDLE;
        step.res_cnt   = 2'd1;
        step.kind      = jsu_pkg::KIND_END;
      end else if (in_char == jsu_pkg::CH_BSLASH) begin
        step.phase_nxt = jsu_pkg::PH_ESC;
      end else begin
        step.res_cnt = 2'd1;
        step.byte0   = in_char;
      end
    end else if (ph == jsu_pkg::PH_ESC) begin
      step.phase_nxt = jsu_pkg::PH_TEXT;
      step.res_cnt   = 2'd1;
      case (in_char)
        jsu_pkg::CH_QUOTE:  step.byte0 = jsu_pkg::CH_QUOTE;
        jsu_pkg::CH_BSLASH: step.byte0 = jsu_pkg::CH_BSLASH;
        jsu_pkg::CH_SLASH:  step.byte0 = jsu_pkg::CH_SLASH;
        jsu_pkg::CH_B:      step.byte0 = 8'h08;
        jsu_pkg::CH_F:      step.byte0 = 8'h0c;
        jsu_pkg::CH_N:      step.byte0 = 8'h0a;
        jsu_pkg::CH_R:      step.byte0 = 8'h0d;
        jsu_pkg::CH_T:      step.byte0 = 8'h09;
        jsu_pkg::CH_U: begin
          step.phase_nxt = jsu_pkg::PH_HEX1;
          step.cp_nxt    = '0;
          step.res_cnt   = 2'd0;
        end
        default: begin
          step.phase_nxt = jsu_pkg::PH_IDLE;
          step.kind      = jsu_pkg::KIND_ERROR;
          step.cause     = jsu_pkg::CAUSE_BAD_ESC;
        end
      endcase
    end else begin
      // hex digit phases
      if (!(is_dig || is_alpha)) begin
        step.phase_nxt = jsu_pkg::PH_IDLE;
        step.res_cnt   = 2'd1;
        step.kind      = jsu_pkg::KIND_ERROR;
        step.cause     = jsu_pkg::CAUSE_BAD_HEX;
      end else begin
        step.cp_nxt = cp_new;
        if (ph != jsu_pkg::PH_HEX4) begin
          step.phase_nxt = ph + 3'd1;
        end else begin
          step.phase_nxt = jsu_pkg::PH_TEXT;
          if (cp_new <= jsu_pkg::CP_MAX1) begin
            step.res_cnt = 2'd1;
            step.byte0   = cp_new[7:0];
          end else if (cp_new <= jsu_pkg::CP_MAX2) begin
            step.res_cnt = 2'd2;
            step.byte0   = {3'b110, cp_new[10:6]};
            step.byte1   = {2'b10, cp_new[5:0]};
          end else begin
            step.res_cnt = 2'd3;
            step.byte0   = {4'b1110, cp_new[15:12]};
            step.byte1   = {2'b10, cp_new[11:6]};
            step.byte2   = {2'b10, cp_new[5:0]};
          end
        end
      end
    end
  end

endmodule

FILE: design/json_string_unescape.sv
// json_string_unescape: decodes a quoted json string one byte per beat into utf-8 bytes
// latency: a result appears on out_ the cycle after its input beat is taken
// throughput while out_ready stays high: one input beat per cycle; a \u escape giving two or three
//   utf-8 bytes holds in_ready low while the extra bytes drain from the result register, one per cycle
// reset (rst_n low, synchronous): waits for an opening quote, length and result queue cleared
// depends on jsu_pkg and jsu_decode
`timescale 1ns / 1ps

module json_string_unescape #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_decoded_length,
  output logic [2:0]  out_error_cause,
  output logic        out_last
);

  localparam int LW = LENGTH_BITS;

  // parser state
  logic [2:0]    phase_r,  phase_nxt;
  logic [15:0]   cp_r,     cp_nxt;
  logic [LW-1:0] len_r,    len_nxt;

  // result register: up to three pending beats from one input byte
  logic [1:0]  cnt_r,   cnt_nxt;
  logic [1:0]  kind_r,  kind_nxt;
  logic [2:0]  cause_r, cause_nxt;
  logic [15:0] shown_r, shown_nxt;
  logic [7:0]  byte_q_r [3];
  logic [7:0]  byte_q_nxt [3];

  jsu_pkg::step_t step;

  logic          in_acc;
  logic          out_acc;
  logic [LW+1:0] sum;
  logic [LW-1:0] len_base;
  logic [1:0]    add;
  logic [LW+15:0] len_ext;

  jsu_decode u_decode (
    .phase      (phase_r),
    .code_point (cp_r),
    .in_char    (in_char),
    .step       (step)
  );

  // the result register takes a new byte's results once it is empty or its last beat leaves
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_acc   = out_valid && out_ready;

  assign out_kind           = kind_r;
  assign out_byte           = byte_q_r[0];
  assign out_decoded_length = shown_r;
  assign out_error_cause    = cause_r;
  assign out_last           = (cnt_r == 2'd1);

  // saturating length update; the count for the close beat is the one before this byte
  always_comb begin
    len_base = step.clear_len ? '0 : len_r;
    add      = (step.kind == jsu_pkg::KIND_DATA) ? step.res_cnt : 2'd0;
    sum      = {2'b00, len_base} + (LW+2)'(add);
    len_nxt  = (sum > {2'b00, {LW{1'b1}}}) ? {LW{1'b1}} : sum[LW-1:0];
    // shown length caps at 16 bits when the counter is wider
    len_ext  = {16'h0000, len_r};
    if (step.kind != jsu_pkg::KIND_END) begin
      shown_nxt = '0;
    end else if (len_ext > (LW+16)'(16'hffff)) begin
      shown_nxt = 16'hffff;
    end else begin
      shown_nxt = len_ext[15:0];
    end
  end

  // parser state and result register next state
  always_comb begin
    phase_nxt  = phase_r;
    cp_nxt     = cp_r;
    cnt_nxt    = cnt_r;
    kind_nxt   = kind_r;
    cause_nxt  = cause_r;
    byte_q_nxt = byte_q_r;
    if (in_acc) begin
      phase_nxt     = step.phase_nxt;
      cp_nxt        = step.cp_nxt;
      cnt_nxt       = step.res_cnt;
      kind_nxt      = step.kind;
      cause_nxt     = step.cause;
      byte_q_nxt[0] = step.byte0;
      byte_q_nxt[1] = step.byte1;
      byte_q_nxt[2] = step.byte2;
    end else if (out_acc) begin
      // shift the next utf-8 byte to the front
      cnt_nxt       = cnt_r - 2'd1;
      byte_q_nxt[0] = byte_q_r[1];
      byte_q_nxt[1] = byte_q_r[2];
      byte_q_nxt[2] = 8'h00;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_IDLE;
      cp_r    <= '0;
      len_r   <= '0;
      cnt_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      cp_r    <= cp_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc) begin
        len_r <= len_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    cause_r  <= cause_nxt;
    byte_q_r <= byte_q_nxt;
    if (in_acc) begin
      shown_r <= shown_nxt;
    end
  end

  // a multi-byte utf-8 run only continues with more data beats
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last && out_ready) |=>
      (out_valid && out_kind == jsu_pkg::KIND_DATA))
    else $error("utf-8 run broken before its last beat");

  // close and error results are always single beats
  a_ctrl_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != jsu_pkg::KIND_DATA) |-> out_last)
    else $error("close or error result not marked last");

  // no new byte is taken while a run still has beats after the current one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input taken while utf-8 run pending");

  // once a byte giving a close or error result is taken the parser is waiting for a quote
  a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && step.kind != jsu_pkg::KIND_DATA && step.res_cnt != 2'd0)
      |=> (phase_r == jsu_pkg::PH_IDLE))
    else $error("parser not idle after close or error");

endmodule
